/* rtl/core/rsc_pkg.sv */
// Package for the range scan to Cartesian point converter.
// Holds shared types, register codes, reset values and sine coefficients.
// No dependencies.
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COL_CNT_W  = 11;
  localparam int ROW_CNT_W  = 7;
  localparam int ANGLE_W    = 16;
  localparam int STEP_W     = 15;
  localparam int DEPTH_W    = 24;
  localparam int INTENS_W   = 16;
  localparam int POS_W      = 25;
  localparam int RING_W     = 6;

  localparam int JOB_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH = 2;

  localparam logic [ANGLE_W-1:0]   AZ_START_RST   = 16'hE000;
  localparam logic [STEP_W-1:0]    AZ_STEP_RST    = 15'd64;
  localparam logic [ANGLE_W-1:0]   INCL_START_RST = 16'hF000;
  localparam logic [STEP_W-1:0]    INCL_STEP_RST  = 15'd2048;
  localparam logic [COL_CNT_W-1:0] COL_CNT_RST    = 11'd257;
  localparam logic [ROW_CNT_W-1:0] ROW_CNT_RST    = 7'd3;

  // Q30 Taylor coefficients of sin(pi/2*u)
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AZ_START   = 3'd0,
    REG_AZ_STEP    = 3'd1,
    REG_INCL_START = 3'd2,
    REG_INCL_STEP  = 3'd3,
    REG_COL_COUNT  = 3'd4,
    REG_ROW_COUNT  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SINE,
    BK_POINT,
    BK_PUSH
  } back_state_e;

  typedef struct packed {
    logic [DEPTH_W-1:0]  depth;
    logic                invalid;
    logic [INTENS_W-1:0] intensity;
    logic [ANGLE_W-1:0]  az;
    logic [ANGLE_W-1:0]  incl;
    logic [RING_W-1:0]   ring;
    logic                frame_end;
    logic                dense;
  } job_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] z_pos;
    logic [INTENS_W-1:0]     intensity;
    logic [RING_W-1:0]       ring;
    logic                    frame_end;
    logic                    dense;
  } result_t;

  // Horner coefficient used at sine step 1..4
  function automatic logic [30:0] sine_coef(input logic [2:0] step);
    logic [30:0] c;
    case (step)
      3'd1:    c = SIN_C7;
      3'd2:    c = SIN_C5;
      3'd3:    c = SIN_C3;
      3'd4:    c = SIN_C1;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/rsc_fifo.sv */
// Small register queue used between the converter stages.
// Depends on nothing; WIDTH and DEPTH set storage.
`timescale 1ns / 1ps

module rsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/core/rsc_front.sv */
// Front stage: configuration registers, scan counters and angle tracking.
// Turns each accepted sample into a job; uses rsc_pkg.
`timescale 1ns / 1ps

module rsc_front #(
  parameter int MAX_COLUMNS = rsc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = rsc_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]    wr_idx_i,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]   wr_data_i,
  input  logic                             push_i,
  input  logic [rsc_pkg::DEPTH_W-1:0]      depth_i,
  input  logic                             depth_invalid_i,
  input  logic [rsc_pkg::INTENS_W-1:0]     intensity_i,
  input  logic                             job_full_i,
  output logic                             job_push_o,
  output rsc_pkg::job_t                    job_o
);

  import rsc_pkg::*;

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int CMPW  = (CW + 1 > COL_CNT_W) ? CW + 1 : COL_CNT_W;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCMPW = (RW + 1 > ROW_CNT_W) ? RW + 1 : ROW_CNT_W;

  logic [ANGLE_W-1:0]   az_start_q, incl_start_q;
  logic [STEP_W-1:0]    az_step_q, incl_step_q;
  logic [COL_CNT_W-1:0] col_cnt_q;
  logic [ROW_CNT_W-1:0] row_cnt_q;

  logic [CW-1:0]        col_q;
  logic [RW-1:0]        row_q;
  logic [ANGLE_W-1:0]   az_q, incl_q;
  logic                 dense_q;

  logic [CMPW-1:0]      cols_ext, cols_eff;
  logic [RCMPW-1:0]     rows_ext, rows_eff;
  logic                 last_col, last_row, accept;
  logic [RW+RING_W-1:0] ring_ext;

  assign accept     = push_i & ~job_full_i;
  assign job_push_o = accept;

  always_comb begin
    cols_ext = CMPW'(col_cnt_q);
    if (cols_ext == '0) begin
      cols_eff = CMPW'(1);
    end else if (cols_ext > CMPW'(MAX_COLUMNS)) begin
      cols_eff = CMPW'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_ext;
    end
    rows_ext = RCMPW'(row_cnt_q);
    if (rows_ext == '0) begin
      rows_eff = RCMPW'(1);
    end else if (rows_ext > RCMPW'(MAX_ROWS)) begin
      rows_eff = RCMPW'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    last_col = (CMPW'(col_q) + CMPW'(1)) >= cols_eff;
    last_row = (RCMPW'(row_q) + RCMPW'(1)) >= rows_eff;
    ring_ext = (RW+RING_W)'(row_q);
  end

  always_comb begin
    job_o.depth     = depth_i;
    job_o.invalid   = depth_invalid_i;
    job_o.intensity = intensity_i;
    job_o.az        = az_q;
    job_o.incl      = incl_q;
    job_o.ring      = ring_ext[RING_W-1:0];
    job_o.frame_end = last_col & last_row;
    job_o.dense     = dense_q & ~depth_invalid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_start_q   <= AZ_START_RST;
      az_step_q    <= AZ_STEP_RST;
      incl_start_q <= INCL_START_RST;
      incl_step_q  <= INCL_STEP_RST;
      col_cnt_q    <= COL_CNT_RST;
      row_cnt_q    <= ROW_CNT_RST;
    end else if (wr_en_i) begin
      case (cfg_reg_e'(wr_idx_i))
        REG_AZ_START:   az_start_q   <= wr_data_i;
        REG_AZ_STEP:    az_step_q    <= wr_data_i[STEP_W-1:0];
        REG_INCL_START: incl_start_q <= wr_data_i;
        REG_INCL_STEP:  incl_step_q  <= wr_data_i[STEP_W-1:0];
        REG_COL_COUNT:  col_cnt_q    <= wr_data_i[COL_CNT_W-1:0];
        REG_ROW_COUNT:  row_cnt_q    <= wr_data_i[ROW_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      az_q    <= AZ_START_RST;
      incl_q  <= INCL_START_RST;
      dense_q <= 1'b1;
    end else if (accept) begin
      if (!last_col) begin
        col_q   <= col_q + CW'(1);
        az_q    <= az_q + ANGLE_W'(az_step_q);
        dense_q <= dense_q & ~depth_invalid_i;
      end else begin
        col_q <= '0;
        az_q  <= az_start_q;
        if (!last_row) begin
          row_q   <= row_q + RW'(1);
          incl_q  <= incl_q + ANGLE_W'(incl_step_q);
          dense_q <= dense_q & ~depth_invalid_i;
        end else begin
          row_q   <= '0;
          incl_q  <= incl_start_q;
          dense_q <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/rsc_back.sv */
// Back stage: shared polynomial sine unit and point multiplier.
// Works one job at a time and pushes the result; uses rsc_pkg.
`timescale 1ns / 1ps

module rsc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rsc_pkg::job_t    job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  output rsc_pkg::result_t res_o,
  output logic             res_push_o,
  input  logic             res_full_i
);

  import rsc_pkg::*;

  back_state_e state_q, state_d;
  logic [1:0]  sel_q;
  logic [2:0]  step_q;

  job_t        job_q;
  logic [30:0] v_q, p_q;
  logic [14:0] mag_q [4];
  logic [3:0]  neg_q;
  logic [38:0] t_q;
  logic signed [POS_W-1:0] x_q, y_q, z_q;

  logic [ANGLE_W-1:0] ang, ang_f;
  logic [1:0]  quad;
  logic [14:0] r;
  logic [30:0] u_c, pm_a, pm_b;
  logic [61:0] pm_prod;
  logic [31:0] pm_hi;
  logic [30:0] p_new;
  logic [16:0] s_rnd;
  logic [14:0] s_mag;
  logic [38:0] xa;
  logic [14:0] xb;
  logic [53:0] xprod;
  logic [DEPTH_W-1:0] rnd15, rnd30;

  function automatic logic signed [POS_W-1:0] signed_pos(input logic [DEPTH_W-1:0] m,
                                                          input logic neg);
    logic signed [POS_W-1:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  // sel: 0 cos az, 1 sin az, 2 cos incl, 3 sin incl
  always_comb begin
    ang   = sel_q[1] ? job_q.incl : job_q.az;
    ang_f = sel_q[0] ? ang : ang + 16'd16384;
    quad  = ang_f[15:14];
    r     = quad[0] ? 15'd16384 - {1'b0, ang_f[13:0]} : {1'b0, ang_f[13:0]};
    u_c   = {r, 16'b0};
    case (step_q)
      3'd0: begin
        pm_a = u_c;
        pm_b = u_c;
      end
      3'd1: begin
        pm_a = SIN_C9;
        pm_b = v_q;
      end
      3'd2, 3'd3, 3'd4: begin
        pm_a = p_q;
        pm_b = v_q;
      end
      default: begin
        pm_a = u_c;
        pm_b = p_q;
      end
    endcase
    pm_prod = 62'(pm_a) * 62'(pm_b);
    pm_hi   = pm_prod[61:30];
    p_new   = 31'(32'(sine_coef(step_q)) - pm_hi);
    s_rnd   = 17'((pm_hi + 32'd16384) >> 15);
    s_mag   = (s_rnd > 17'd32767) ? 15'h7FFF : s_rnd[14:0];
  end

  always_comb begin
    case (step_q[1:0])
      2'd0: begin
        xa = 39'(job_q.depth);
        xb = mag_q[2];
      end
      2'd1: begin
        xa = 39'(job_q.depth);
        xb = mag_q[3];
      end
      2'd2: begin
        xa = t_q;
        xb = mag_q[0];
      end
      default: begin
        xa = t_q;
        xb = mag_q[1];
      end
    endcase
    xprod = 54'(xa) * 54'(xb);
    rnd15 = DEPTH_W'((xprod + (54'd1 << 14)) >> 15);
    rnd30 = DEPTH_W'((xprod + (54'd1 << 29)) >> 30);
  end

  always_comb begin
    state_d    = state_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          state_d   = BK_SINE;
        end
      end
      BK_SINE: begin
        if (step_q == 3'd5 && sel_q == 2'd3) begin
          state_d = BK_POINT;
        end
      end
      BK_POINT: begin
        if (step_q == 3'd3) begin
          state_d = BK_PUSH;
        end
      end
      BK_PUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      sel_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        BK_SINE: begin
          if (step_q == 3'd5) begin
            step_q <= '0;
            sel_q  <= sel_q + 2'd1;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        BK_POINT: begin
          step_q <= (step_q == 3'd3) ? 3'd0 : step_q + 3'd1;
        end
        default: begin
          step_q <= '0;
          sel_q  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          job_q <= job_i;
        end
      end
      BK_SINE: begin
        case (step_q)
          3'd0:             v_q <= pm_hi[30:0];
          3'd1, 3'd2, 3'd3, 3'd4: p_q <= p_new;
          default: begin
            mag_q[sel_q] <= s_mag;
            neg_q[sel_q] <= quad[1];
          end
        endcase
      end
      BK_POINT: begin
        case (step_q[1:0])
          2'd0:    t_q <= xprod[38:0];
          2'd1:    z_q <= signed_pos(rnd15, neg_q[3]);
          2'd2:    x_q <= signed_pos(rnd30, neg_q[2] ^ neg_q[0]);
          default: y_q <= signed_pos(rnd30, neg_q[2] ^ neg_q[1]);
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.x_pos     = job_q.invalid ? '0 : x_q;
    res_o.y_pos     = job_q.invalid ? '0 : y_q;
    res_o.z_pos     = job_q.invalid ? '0 : z_q;
    res_o.intensity = job_q.intensity;
    res_o.ring      = job_q.ring;
    res_o.frame_end = job_q.frame_end;
    res_o.dense     = job_q.dense;
  end

endmodule

/* rtl/core/range_scan_to_cartesian_points.sv */
// Range scan to Cartesian points, top level: front, job queue, back, result queue.
// The back stage works one job at a time: it takes a job from the job queue, runs the
// shared sine multiplier (4 angles x 6 steps) and 4 point multiplies, then hands over its
// result once the result queue has room; only then does it take the next job.
// The job queue holds 2 samples beside the one in the back stage, so an idle block
// takes an input burst of 3 at once.
// Reset is asynchronous and active low; it restores the register defaults and
// restarts the scan at column 0, row 0 with the dense flag set. No clearing pass.
`timescale 1ns / 1ps

module range_scan_to_cartesian_points #(
  parameter int MAX_COLUMNS = rsc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = rsc_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]       wr_idx_i,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]      wr_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic [rsc_pkg::DEPTH_W-1:0]         depth_i,
  input  logic                                depth_invalid_i,
  input  logic [rsc_pkg::INTENS_W-1:0]        intensity_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [rsc_pkg::POS_W-1:0]    x_pos_o,
  output logic signed [rsc_pkg::POS_W-1:0]    y_pos_o,
  output logic signed [rsc_pkg::POS_W-1:0]    z_pos_o,
  output logic [rsc_pkg::INTENS_W-1:0]        intensity_out_o,
  output logic [rsc_pkg::RING_W-1:0]          ring_o,
  output logic                                frame_end_o,
  output logic                                frame_dense_o
);

  import rsc_pkg::*;

  job_t    job_wr, job_rd;
  result_t res_wr, res_rd;
  logic [$bits(job_t)-1:0]    job_rdata;
  logic [$bits(result_t)-1:0] res_rdata;
  logic job_push, job_full, job_pop, job_empty;
  logic res_push, res_full;

  assign full   = job_full;
  assign job_rd = job_t'(job_rdata);
  assign res_rd = result_t'(res_rdata);

  rsc_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (wr_en_i),
    .wr_idx_i       (wr_idx_i),
    .wr_data_i      (wr_data_i),
    .push_i         (push),
    .depth_i        (depth_i),
    .depth_invalid_i(depth_invalid_i),
    .intensity_i    (intensity_i),
    .job_full_i     (job_full),
    .job_push_o     (job_push),
    .job_o          (job_wr)
  );

  rsc_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(JOB_Q_DEPTH)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_wr),
    .full_o (job_full),
    .pop_i  (job_pop),
    .rdata_o(job_rdata),
    .empty_o(job_empty)
  );

  rsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_rd),
    .job_empty_i(job_empty),
    .job_pop_o  (job_pop),
    .res_o      (res_wr),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  rsc_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_Q_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_wr),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign x_pos_o         = res_rd.x_pos;
  assign y_pos_o         = res_rd.y_pos;
  assign z_pos_o         = res_rd.z_pos;
  assign intensity_out_o = res_rd.intensity;
  assign ring_o          = res_rd.ring;
  assign frame_end_o     = res_rd.frame_end;
  assign frame_dense_o   = res_rd.dense;

endmodule

/* tb/tb.sv */
// Self-checking bench for range_scan_to_cartesian_points: directed and random scans,
// a scan-order point predictor, and register rewrites between bursts of requests.
// Depends on rsc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
  import rsc_pkg::*;

  localparam int ITEM_TOTAL     = 1350;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum {PACE_STEADY, PACE_SPARSE, PACE_ROUGH} pace_e;

  typedef struct packed {
    logic [DEPTH_W-1:0]  depth;
    logic                invalid;
    logic [INTENS_W-1:0] intensity;
  } sample_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  wr_en_i         = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_idx_i        = '0;
  logic [CFG_DATA_W-1:0] wr_data_i       = '0;
  logic                  push            = 1'b0;
  logic                  full;
  logic [DEPTH_W-1:0]    depth_i         = '0;
  logic                  depth_invalid_i = 1'b0;
  logic [INTENS_W-1:0]   intensity_i     = '0;
  logic                  empty;
  logic                  pop             = 1'b0;
  logic signed [POS_W-1:0] x_pos_o, y_pos_o, z_pos_o;
  logic [INTENS_W-1:0]   intensity_out_o;
  logic [RING_W-1:0]     ring_o;
  logic                  frame_end_o;
  logic                  frame_dense_o;

  range_scan_to_cartesian_points u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_en_i         (wr_en_i),
    .wr_idx_i        (wr_idx_i),
    .wr_data_i       (wr_data_i),
    .push            (push),
    .full            (full),
    .depth_i         (depth_i),
    .depth_invalid_i (depth_invalid_i),
    .intensity_i     (intensity_i),
    .empty           (empty),
    .pop             (pop),
    .x_pos_o         (x_pos_o),
    .y_pos_o         (y_pos_o),
    .z_pos_o         (z_pos_o),
    .intensity_out_o (intensity_out_o),
    .ring_o          (ring_o),
    .frame_end_o     (frame_end_o),
    .frame_dense_o   (frame_dense_o)
  );

  always #10 clk_i = ~clk_i;

  // scan geometry registers as the block should hold them
  logic [ANGLE_W-1:0]   az_start   = AZ_START_RST;
  logic [STEP_W-1:0]    az_step    = AZ_STEP_RST;
  logic [ANGLE_W-1:0]   incl_start = INCL_START_RST;
  logic [STEP_W-1:0]    incl_step  = INCL_STEP_RST;
  logic [COL_CNT_W-1:0] col_count  = COL_CNT_RST;
  logic [ROW_CNT_W-1:0] row_count  = ROW_CNT_RST;

  // scan position
  logic [9:0]           col_idx  = '0;
  logic [RING_W-1:0]    row_idx  = '0;
  logic [ANGLE_W-1:0]   az_ang   = AZ_START_RST;
  logic [ANGLE_W-1:0]   incl_ang = INCL_START_RST;
  logic                 dense    = 1'b1;

  sample_t scans_pending[$];
  result_t points_due[$];
  sample_t cur;
  result_t got, want;

  pace_e send_pace = PACE_ROUGH;
  pace_e take_pace = PACE_ROUGH;
  int    bad_pct   = 5;
  int    gap_left  = 0;
  int    stall_left = 0;
  int    take_wait  = 0;
  int    quiet_cycles = 0;
  int    n_queued  = 0;
  int    n_taken   = 0;
  int    n_points  = 0;
  int    n_frames  = 0;
  int    n_invalid = 0;
  int    n_writes  = 0;
  int    n_errors  = 0;

  function automatic logic [15:0] quarter_wave(input logic [14:0] r);
    logic [63:0] u, v, p, s;
    u = 64'(r) << 16;
    v = (u * u) >> 30;
    p = 64'(SIN_C9);
    p = 64'(SIN_C7) - ((p * v) >> 30);
    p = 64'(SIN_C5) - ((p * v) >> 30);
    p = 64'(SIN_C3) - ((p * v) >> 30);
    p = 64'(SIN_C1) - ((p * v) >> 30);
    s = (((u * p) >> 30) + 64'd16384) >> 15;
    return (s > 64'd32767) ? 16'd32767 : s[15:0];
  endfunction

  function automatic logic signed [15:0] sin_q15(input logic [ANGLE_W-1:0] a);
    logic [14:0] r;
    logic [15:0] m;
    r = {1'b0, a[13:0]};
    if (a[14]) r = 15'd16384 - r;
    m = quarter_wave(r);
    return a[15] ? -m : m;
  endfunction

  function automatic logic signed [15:0] cos_q15(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] b;
    b = a + 16'h4000;
    return sin_q15(b);
  endfunction

  // half away from zero
  function automatic longint round_away(input longint prod, input int sh);
    longint m;
    m = (prod < 0) ? -prod : prod;
    m = (m + (longint'(1) << (sh - 1))) >> sh;
    return (prod < 0) ? -m : m;
  endfunction

  function automatic result_t project_sample(input sample_t s);
    result_t r;
    int      cols, rows;
    longint  d, t;
    logic    last_col, last_row;
    cols = col_count;
    rows = row_count;
    if (cols < 1) cols = 1;
    if (cols > MAX_COLUMNS_DEF) cols = MAX_COLUMNS_DEF;
    if (rows < 1) rows = 1;
    if (rows > MAX_ROWS_DEF) rows = MAX_ROWS_DEF;
    r = '0;
    if (s.invalid) begin
      dense = 1'b0;
    end else begin
      d = s.depth;
      t = d * cos_q15(incl_ang);
      r.x_pos = POS_W'(round_away(t * cos_q15(az_ang), 30));
      r.y_pos = POS_W'(round_away(t * sin_q15(az_ang), 30));
      r.z_pos = POS_W'(round_away(d * sin_q15(incl_ang), 15));
    end
    last_col    = (int'(col_idx) + 1) >= cols;
    last_row    = (int'(row_idx) + 1) >= rows;
    r.intensity = s.intensity;
    r.ring      = row_idx;
    r.frame_end = last_col && last_row;
    r.dense     = dense;
    if (!last_col) begin
      col_idx = col_idx + 1'b1;
      az_ang  = az_ang + {1'b0, az_step};
    end else begin
      col_idx = '0;
      az_ang  = az_start;
      if (!last_row) begin
        row_idx  = row_idx + 1'b1;
        incl_ang = incl_ang + {1'b0, incl_step};
      end else begin
        row_idx  = '0;
        incl_ang = incl_start;
        dense    = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int draw_wait(input pace_e p);
    case (p)
      PACE_STEADY: return 0;
      PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
      default:     return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(0, 7))
      0:       s.depth = '0;
      1:       s.depth = '1;
      2:       s.depth = DEPTH_W'($urandom_range(0, 255));
      default: s.depth = DEPTH_W'($urandom);
    endcase
    s.invalid   = $urandom_range(0, 99) < bad_pct;
    s.intensity = INTENS_W'($urandom);
    return s;
  endfunction

  function automatic logic [15:0] pick_count(input int top, input logic [15:0] cap);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return cap;
      2:       return cap + 16'd1;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(1, top));
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(0, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_scan(input sample_t s);
    scans_pending.insert(scans_pending.size(), s);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    wr_en_i   <= 1'b1;
    wr_idx_i  <= idx;
    wr_data_i <= data;
    case (idx)
      REG_AZ_START:   az_start   = data;
      REG_AZ_STEP:    az_step    = data[STEP_W-1:0];
      REG_INCL_START: incl_start = data;
      REG_INCL_STEP:  incl_step  = data[STEP_W-1:0];
      REG_COL_COUNT:  col_count  = data[COL_CNT_W-1:0];
      REG_ROW_COUNT:  row_count  = data[ROW_CNT_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    wr_en_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (scans_pending.size() != 0 || push || points_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_setup();
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
    int                   n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      idx = CFG_IDX_W'($urandom_range(0, 7));
      case (idx)
        REG_COL_COUNT: data = pick_count(8, 16'd1024);
        REG_ROW_COUNT: data = pick_count(6, 16'd64);
        default:       data = pick_angle();
      endcase
      write_reg(idx, data);
    end
    end_writes();
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      gap_left <= 0;
    end else begin
      if (push && !full) begin
        want = project_sample(cur);
        points_due.insert(points_due.size(), want);
        n_taken++;
        if (cur.invalid) n_invalid++;
        if (want.frame_end) n_frames++;
      end
      if (!push || !full) begin
        if (gap_left != 0) begin
          push     <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (scans_pending.size() != 0) begin
          cur              = scans_pending.pop_front();
          push            <= 1'b1;
          depth_i         <= cur.depth;
          depth_invalid_i <= cur.invalid;
          intensity_i     <= cur.intensity;
          gap_left        <= draw_wait(send_pace);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic flag_field(input string name, input longint want_v, input longint got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    n_errors++;
  endtask

  // point monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      stall_left <= 0;
    end else if (pop && !empty) begin
      got.x_pos     = x_pos_o;
      got.y_pos     = y_pos_o;
      got.z_pos     = z_pos_o;
      got.intensity = intensity_out_o;
      got.ring      = ring_o;
      got.frame_end = frame_end_o;
      got.dense     = frame_dense_o;
      n_points++;
      if (points_due.size() == 0) begin
        $display("%0t: point with no request pending, expected none, got x %0d y %0d z %0d",
                 $time, got.x_pos, got.y_pos, got.z_pos);
        n_errors++;
      end else begin
        want = points_due.pop_front();
        if (got.x_pos !== want.x_pos) flag_field("x_pos", want.x_pos, got.x_pos);
        if (got.y_pos !== want.y_pos) flag_field("y_pos", want.y_pos, got.y_pos);
        if (got.z_pos !== want.z_pos) flag_field("z_pos", want.z_pos, got.z_pos);
        if (got.intensity !== want.intensity)
          flag_field("intensity_out", want.intensity, got.intensity);
        if (got.ring !== want.ring) flag_field("ring", want.ring, got.ring);
        if (got.frame_end !== want.frame_end)
          flag_field("frame_end", want.frame_end, got.frame_end);
        if (got.dense !== want.dense) flag_field("frame_dense", want.dense, got.dense);
      end
      take_wait   = draw_wait(take_pace);
      stall_left <= take_wait;
      pop        <= (take_wait == 0);
    end else if (!pop) begin
      if (stall_left <= 1) pop <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no request or point moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry, depth and intensity extremes
    queue_scan('{24'h000000, 1'b0, 16'h0000});
    queue_scan('{24'hFFFFFF, 1'b0, 16'hFFFF});
    queue_scan('{24'hFFFFFF, 1'b1, 16'hA5A5});
    queue_scan('{24'h000001, 1'b0, 16'h5A5A});
    queue_scan('{24'h800000, 1'b0, 16'h0000});
    queue_scan('{24'h7FFFFF, 1'b0, 16'hFFFF});
    n_queued += 6;
    wait_idle();

    // shrink counts mid-row, angle extremes, spare indexes ignored
    write_reg(REG_COL_COUNT, 16'd3);
    write_reg(REG_ROW_COUNT, 16'd2);
    write_reg(REG_AZ_START, 16'h8000);
    write_reg(REG_AZ_STEP, 16'h7FFF);
    write_reg(REG_INCL_START, 16'h7FFF);
    write_reg(REG_INCL_STEP, 16'h0000);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0001);
    end_writes();
    queue_scan('{24'h123456, 1'b0, 16'h0001});
    queue_scan('{24'hFFFFFF, 1'b1, 16'h0002});
    queue_scan('{24'h00FFFF, 1'b0, 16'h0003});
    queue_scan('{24'hFFFFFF, 1'b0, 16'h0004});
    queue_scan('{24'h000000, 1'b0, 16'h0005});
    queue_scan('{24'hABCDEF, 1'b0, 16'h0006});
    queue_scan('{24'hFFFFFF, 1'b0, 16'h0007});
    queue_scan('{24'h000100, 1'b0, 16'h0008});
    n_queued += 8;
    wait_idle();

    // zero counts clamp to one: every sample ends a frame
    write_reg(REG_COL_COUNT, 16'd0);
    write_reg(REG_ROW_COUNT, 16'd0);
    write_reg(REG_AZ_START, 16'h7FFF);
    write_reg(REG_AZ_STEP, 16'hFFFF);
    write_reg(REG_INCL_START, 16'h8000);
    write_reg(REG_INCL_STEP, 16'h7FFF);
    end_writes();
    queue_scan('{24'hFFFFFF, 1'b0, 16'hFFFF});
    queue_scan('{24'hFFFFFF, 1'b1, 16'h0000});
    queue_scan('{24'h400000, 1'b0, 16'h8000});
    n_queued += 3;
    wait_idle();

    // oversized counts clamp to the maximum
    write_reg(REG_COL_COUNT, 16'h07FF);
    write_reg(REG_ROW_COUNT, 16'h007F);
    end_writes();
    queue_scan('{24'hFFFFFF, 1'b0, 16'h1234});
    queue_scan('{24'h000001, 1'b0, 16'h4321});
    queue_scan('{24'hFFFFFE, 1'b1, 16'hFFFF});
    n_queued += 3;
    wait_idle();

    // one column, full ring range
    send_pace = PACE_STEADY;
    take_pace = PACE_SPARSE;
    write_reg(REG_COL_COUNT, 16'd1);
    write_reg(REG_ROW_COUNT, 16'd64);
    write_reg(REG_INCL_STEP, 16'd512);
    end_writes();
    repeat (130) queue_scan(random_sample());
    n_queued += 130;
    wait_idle();

    while (n_queued < ITEM_TOTAL) begin
      random_setup();
      send_pace = pace_e'($urandom_range(0, 2));
      take_pace = pace_e'($urandom_range(0, 2));
      case ($urandom_range(0, 2))
        0:       bad_pct = 0;
        1:       bad_pct = 5;
        default: bad_pct = 30;
      endcase
      n = $urandom_range(20, 120);
      repeat (n) queue_scan(random_sample());
      n_queued += n;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Converted %0d samples (%0d invalid) into %0d points, %0d frame ends,",
             n_taken, n_invalid, n_points, n_frames);
    $display("across %0d register writes and %0d mismatches.", n_writes, n_errors);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
